// ----- src/fsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types, codes and the Q0.16 divide-by-one helper for the focal
// sampling probability engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

	localparam logic [15:0] ONE_Q16 = 16'hFFFF;

	typedef enum logic [2:0] {
		CMD_LOAD_CDF   = 3'd0,
		CMD_LOAD_RATIO = 3'd1,
		CMD_LOAD_PRIOR = 3'd2,
		CMD_RESTART    = 3'd3,
		CMD_SAMPLE     = 3'd4,
		CMD_UPDATE     = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_NUM_CAND  = 2'd0,
		CFG_CDF_LAST  = 2'd1,
		CFG_ITER_LAST = 2'd2,
		CFG_MIN_RATIO = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RST_RD,
		ST_RST_WR,
		ST_SMP_RD,
		ST_SMP_CHK,
		ST_UPD_SETUP,
		ST_CAND_RD,
		ST_CAND_ACC,
		ST_CAND_REACH,
		ST_CAND_WT,
		ST_CAND_WR,
		ST_NORM_RD,
		ST_NORM_DIV,
		ST_NORM_WAIT,
		ST_LK_MUL,
		ST_LK_SPLIT,
		ST_LK_LO,
		ST_LK_HI,
		ST_LK_INT,
		ST_DONE
	} state_t;

	// walk order of an update: below the best, the best itself, above it
	typedef enum logic [1:0] {
		PH_DOWN,
		PH_MID,
		PH_UP
	} phase_t;

	typedef struct packed {
		logic [16:0] q;
		logic [15:0] r;
	} dq_t;

	// floor(x / 65535) and remainder, valid for x < 65535 * 65535
	function automatic dq_t div_one_q16(input logic [31:0] x);
		logic [16:0] r;
		dq_t         d;
		r = {1'b0, x[15:0]} + {1'b0, x[31:16]};
		if (r >= {1'b0, ONE_Q16}) begin
			d.q = {1'b0, x[31:16]} + 17'd1;
			d.r = 16'(r - {1'b0, ONE_Q16});
		end else begin
			d.q = {1'b0, x[31:16]};
			d.r = r[15:0];
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- src/fsp_div.sv -----
// ----------------------------------------------------------------------------
// fsp_div
// Radix-2 restoring divider, one quotient bit per cycle, 16-bit quotient.
// The caller guarantees num[47:16] < den.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_div #(
	parameter int DEN_W = 38
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [47:0]      num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [15:0]           quo
);

	logic             busy_q;
	logic [3:0]       cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [15:0]      low_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, low_q[15]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num[47:16]);
			low_q <= num[15:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			low_q <= {low_q[14:0], 1'b0};
			quo   <= {quo[14:0], fits};
		end
	end

endmodule

`default_nettype wire

// ----- src/focal_sampling_probability_engine.sv -----
// ----------------------------------------------------------------------------
// focal_sampling_probability_engine
// Keeps cdf / ratio / prior tables, draw counts and sampling chances in
// on-chip memories and runs load, restart, sample and update commands.
// ----------------------------------------------------------------------------
// One command is in flight at a time. A load writes its table entry when
// the slot is in range; restart reads and writes each candidate in use,
// and sample reads and checks candidates until the draw lands or the last
// one is passed. An update runs a cdf lookup (shorter when the index
// clamps) for the best ratio, then per candidate a count/ratio read, a
// lookup where the reachable ratio beats the best, a weight multiply and
// write, then per candidate a weight read and a division for
// normalization. Every state access goes through memories with
// registered read data, which sets these steps.
// A finished result is held in an output register so the next command can
// be taken.
`default_nettype none

module focal_sampling_probability_engine #(
	parameter int MAX_CANDIDATES = 64,
	parameter int CDF_DEPTH      = 1024,
	parameter int RATIO_DEPTH    = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [11:0] slot,
	input  wire logic [15:0] payload,
	input  wire logic        best_known,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [5:0]       picked,
	output logic             pick_ok,
	output logic [15:0]      max_chance,
	output logic             better_possible,
	output logic             finished
);

	localparam int CIW   = $clog2(MAX_CANDIDATES);
	localparam int NW    = $clog2(MAX_CANDIDATES + 1);
	localparam int CDW   = $clog2(CDF_DEPTH);
	localparam int RIW   = $clog2(RATIO_DEPTH);
	localparam int TOT_W = 32 + $clog2(MAX_CANDIDATES);
	localparam int SUM_W = 16 + NW;

	// memories
	logic [15:0] cdf_mem    [CDF_DEPTH];
	logic [15:0] ratio_mem  [RATIO_DEPTH];
	logic [15:0] prior_mem  [MAX_CANDIDATES];
	logic [15:0] chance_mem [MAX_CANDIDATES];
	logic [31:0] count_mem  [MAX_CANDIDATES];
	logic [31:0] wt_mem     [MAX_CANDIDATES];

	logic           cdf_we, cdf_re, ratio_we, ratio_re, prior_we, prior_re;
	logic           chance_we, chance_re, count_we, count_re, wt_we, wt_re;
	logic [CDW-1:0] cdf_wa, cdf_ra;
	logic [RIW-1:0] ratio_wa, ratio_ra;
	logic [CIW-1:0] prior_wa;
	logic [15:0]    chance_wd;
	logic [31:0]    count_wd;
	logic [15:0]    cdf_rd_q, ratio_rd_q, prior_rd_q, chance_rd_q;
	logic [31:0]    count_rd_q, wt_rd_q;

	// control
	fsp_pkg::state_t      state_q, state_d;
	fsp_pkg::phase_t      phase_q;
	logic                 out_valid_q;
	logic [MAX_CANDIDATES-1:0] chance_vld_q, count_vld_q;
	logic [6:0]           num_cand_q;
	logic [9:0]           cdf_last_q;
	logic [11:0]          iter_last_q;
	logic [15:0]          min_ratio_q;

	// datapath
	logic [2:0]       cmd_q;
	logic [11:0]      slot_q;
	logic [15:0]      pay_q;
	logic             known_q, dep_q;
	logic [NW-1:0]    n_q;
	logic [CIW-1:0]   idx_q;
	logic [12:0]      acc_q;
	logic [SUM_W-1:0] sum_q;
	logic [15:0]      cdf_best_q, maxp_q;
	logic             better_q;
	logic [TOT_W-1:0] total_q;
	logic [31:0]      wt_q;
	logic [5:0]       res_picked_q;
	logic             res_ok_q;
	logic [5:0]       picked_q;
	logic             pick_ok_q, better_out_q, finished_q;
	logic [15:0]      max_out_q;

	// cdf lookup
	logic [15:0]    lk_ratio_q, lk_res_q, lk_lo_q, lk_frac_q;
	logic [25:0]    lk_prod_q;
	logic [31:0]    lk_prod2_q;
	logic [CDW-1:0] lk_addr_q;
	logic           lk_clamp_q, lk_up_q, lk_for_best_q;

	logic             accept;
	logic [31:0]      n_full;
	logic [NW-1:0]    n_new;
	logic             last_idx;
	fsp_pkg::dq_t     split_d, int_d;
	logic             split_clamp;
	logic [CDW-1:0]   split_addr;
	logic [31:0]      cnt_eff;
	logic [32:0]      acc_sum;
	logic [12:0]      acc_new;
	logic [31:0]      ratio_lim;
	logic [15:0]      chance_eff;
	logic [SUM_W-1:0] sum_new;
	logic [15:0]      p_new;
	logic             walk_done;
	logic             upd_dep;
	logic             div_start, div_done;
	logic [15:0]      div_quo;
	logic [47:0]      div_num;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != fsp_pkg::ST_IDLE;
	assign last_idx = (NW'(idx_q) + NW'(1)) == n_q;

	assign n_full = (num_cand_q == 7'd0) ? 32'd1 :
		((32'(num_cand_q) > MAX_CANDIDATES) ? MAX_CANDIDATES : 32'(num_cand_q));
	assign n_new  = NW'(n_full);

	assign split_d     = fsp_pkg::div_one_q16({6'd0, lk_prod_q});
	assign split_clamp = (split_d.q >= {7'd0, cdf_last_q}) ||
		(32'(split_d.q) >= CDF_DEPTH - 1);
	assign split_addr  = (32'(split_d.q) >= CDF_DEPTH - 1) ? CDW'(CDF_DEPTH - 1) :
		CDW'(split_d.q);
	assign int_d       = fsp_pkg::div_one_q16(lk_prod2_q);

	// count summed outward, clamped at 4096 before the ratio-table index limit
	assign cnt_eff   = count_vld_q[idx_q] ? count_rd_q : 32'd0;
	assign acc_sum   = (dep_q && phase_q != fsp_pkg::PH_MID) ?
		(33'(acc_q) + 33'(cnt_eff)) : 33'(cnt_eff);
	assign acc_new   = (acc_sum > 33'd4096) ? 13'd4096 : acc_sum[12:0];
	assign ratio_lim = (32'(iter_last_q) > RATIO_DEPTH - 1) ? RATIO_DEPTH - 1 :
		32'(iter_last_q);

	assign chance_eff = chance_vld_q[idx_q] ? chance_rd_q : 16'd0;
	assign sum_new    = sum_q + SUM_W'(chance_eff);
	assign p_new      = (lk_res_q > cdf_best_q) ? (lk_res_q - cdf_best_q) : 16'd0;

	assign upd_dep = known_q && (slot_q < 12'(n_q)) && (pay_q > min_ratio_q);

	always_comb begin
		case (phase_q)
			fsp_pkg::PH_DOWN: walk_done = 1'b0;
			fsp_pkg::PH_MID:  walk_done = (NW'(slot_q) + NW'(1)) == n_q;
			fsp_pkg::PH_UP:   walk_done = last_idx;
			default:          walk_done = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fsp_pkg::ST_IDLE: begin
				if (accept) begin
					case (command)
						fsp_pkg::CMD_RESTART: state_d = fsp_pkg::ST_RST_RD;
						fsp_pkg::CMD_SAMPLE:  state_d = fsp_pkg::ST_SMP_RD;
						fsp_pkg::CMD_UPDATE:  state_d = fsp_pkg::ST_LK_MUL;
						default:              state_d = fsp_pkg::ST_DONE;
					endcase
				end
			end
			fsp_pkg::ST_RST_RD: state_d = fsp_pkg::ST_RST_WR;
			fsp_pkg::ST_RST_WR: state_d = last_idx ? fsp_pkg::ST_DONE : fsp_pkg::ST_RST_RD;
			fsp_pkg::ST_SMP_RD: state_d = fsp_pkg::ST_SMP_CHK;
			fsp_pkg::ST_SMP_CHK: begin
				if ({16'd0, pay_q} < 32'(sum_new) || last_idx)
					state_d = fsp_pkg::ST_DONE;
				else
					state_d = fsp_pkg::ST_SMP_RD;
			end
			fsp_pkg::ST_UPD_SETUP: state_d = fsp_pkg::ST_CAND_RD;
			fsp_pkg::ST_CAND_RD:   state_d = fsp_pkg::ST_CAND_ACC;
			fsp_pkg::ST_CAND_ACC:  state_d = fsp_pkg::ST_CAND_REACH;
			fsp_pkg::ST_CAND_REACH: begin
				state_d = (ratio_rd_q <= pay_q) ? fsp_pkg::ST_CAND_WR : fsp_pkg::ST_LK_MUL;
			end
			fsp_pkg::ST_CAND_WT: state_d = fsp_pkg::ST_CAND_WR;
			fsp_pkg::ST_CAND_WR: state_d = walk_done ? fsp_pkg::ST_NORM_RD : fsp_pkg::ST_CAND_RD;
			fsp_pkg::ST_NORM_RD:  state_d = fsp_pkg::ST_NORM_DIV;
			fsp_pkg::ST_NORM_DIV: state_d = fsp_pkg::ST_NORM_WAIT;
			fsp_pkg::ST_NORM_WAIT: begin
				if (total_q == '0 || div_done)
					state_d = last_idx ? fsp_pkg::ST_DONE : fsp_pkg::ST_NORM_RD;
			end
			fsp_pkg::ST_LK_MUL:   state_d = fsp_pkg::ST_LK_SPLIT;
			fsp_pkg::ST_LK_SPLIT: state_d = fsp_pkg::ST_LK_LO;
			fsp_pkg::ST_LK_LO: begin
				if (lk_clamp_q)
					state_d = lk_for_best_q ? fsp_pkg::ST_UPD_SETUP : fsp_pkg::ST_CAND_WT;
				else
					state_d = fsp_pkg::ST_LK_HI;
			end
			fsp_pkg::ST_LK_HI: state_d = fsp_pkg::ST_LK_INT;
			fsp_pkg::ST_LK_INT: begin
				state_d = lk_for_best_q ? fsp_pkg::ST_UPD_SETUP : fsp_pkg::ST_CAND_WT;
			end
			fsp_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall)
					state_d = fsp_pkg::ST_IDLE;
			end
			default: state_d = fsp_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		cdf_we    = accept && command == fsp_pkg::CMD_LOAD_CDF &&
			{20'd0, slot} < CDF_DEPTH;
		cdf_wa    = CDW'(slot);
		ratio_we  = accept && command == fsp_pkg::CMD_LOAD_RATIO &&
			{20'd0, slot} < RATIO_DEPTH;
		ratio_wa  = RIW'(slot);
		prior_we  = accept && command == fsp_pkg::CMD_LOAD_PRIOR &&
			{20'd0, slot} < MAX_CANDIDATES;
		prior_wa  = CIW'(slot);
		cdf_re    = 1'b0;
		cdf_ra    = lk_addr_q;
		ratio_re  = state_q == fsp_pkg::ST_CAND_ACC;
		ratio_ra  = (32'(acc_new) > ratio_lim) ? RIW'(ratio_lim) : RIW'(acc_new);
		prior_re  = state_q == fsp_pkg::ST_RST_RD || state_q == fsp_pkg::ST_CAND_RD;
		chance_re = state_q == fsp_pkg::ST_SMP_RD;
		count_re  = state_q == fsp_pkg::ST_SMP_RD || state_q == fsp_pkg::ST_CAND_RD;
		wt_re     = state_q == fsp_pkg::ST_NORM_RD;
		chance_we = 1'b0;
		chance_wd = prior_rd_q;
		count_we  = 1'b0;
		count_wd  = (cnt_eff == 32'hFFFF_FFFF) ? cnt_eff : cnt_eff + 32'd1;
		wt_we     = state_q == fsp_pkg::ST_CAND_WR;
		div_start = state_q == fsp_pkg::ST_NORM_DIV && total_q != '0;
		div_num   = {wt_rd_q, 16'd0} - {16'd0, wt_rd_q};
		case (state_q)
			fsp_pkg::ST_RST_WR: chance_we = 1'b1;
			fsp_pkg::ST_SMP_CHK: count_we = {16'd0, pay_q} < 32'(sum_new);
			fsp_pkg::ST_NORM_WAIT: begin
				chance_we = total_q == '0 || div_done;
				chance_wd = (total_q == '0) ? 16'd0 : div_quo;
			end
			fsp_pkg::ST_LK_SPLIT: begin
				cdf_re = 1'b1;
				cdf_ra = split_addr;
			end
			fsp_pkg::ST_LK_LO: begin
				cdf_re = !lk_clamp_q;
				cdf_ra = lk_addr_q + CDW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cdf_we)    cdf_mem[cdf_wa] <= payload;
		if (cdf_re)    cdf_rd_q <= cdf_mem[cdf_ra];
		if (ratio_we)  ratio_mem[ratio_wa] <= payload;
		if (ratio_re)  ratio_rd_q <= ratio_mem[ratio_ra];
		if (prior_we)  prior_mem[prior_wa] <= payload;
		if (prior_re)  prior_rd_q <= prior_mem[idx_q];
		if (chance_we) chance_mem[idx_q] <= chance_wd;
		if (chance_re) chance_rd_q <= chance_mem[idx_q];
		if (count_we)  count_mem[idx_q] <= count_wd;
		if (count_re)  count_rd_q <= count_mem[idx_q];
		if (wt_we)     wt_mem[idx_q] <= wt_q;
		if (wt_re)     wt_rd_q <= wt_mem[idx_q];
	end

	fsp_div #(
		.DEN_W(TOT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (total_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fsp_pkg::ST_IDLE;
			out_valid_q  <= 1'b0;
			chance_vld_q <= '0;
			count_vld_q  <= '0;
			num_cand_q   <= 7'd1;
			cdf_last_q   <= 10'd1023;
			iter_last_q  <= 12'd4095;
			min_ratio_q  <= 16'd6554;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					fsp_pkg::CFG_NUM_CAND:  num_cand_q  <= cfg_data[6:0];
					fsp_pkg::CFG_CDF_LAST:  cdf_last_q  <= cfg_data[9:0];
					fsp_pkg::CFG_ITER_LAST: iter_last_q <= cfg_data[11:0];
					fsp_pkg::CFG_MIN_RATIO: min_ratio_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == fsp_pkg::ST_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (accept && command == fsp_pkg::CMD_RESTART) begin
				chance_vld_q <= '0;
				count_vld_q  <= '0;
			end
			if (chance_we)
				chance_vld_q[idx_q] <= 1'b1;
			if (count_we)
				count_vld_q[idx_q] <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			fsp_pkg::ST_IDLE: begin
				cmd_q         <= command;
				slot_q        <= slot;
				pay_q         <= payload;
				known_q       <= best_known;
				n_q           <= n_new;
				idx_q         <= '0;
				sum_q         <= '0;
				maxp_q        <= '0;
				better_q      <= 1'b0;
				total_q       <= '0;
				res_picked_q  <= '0;
				res_ok_q      <= 1'b0;
				lk_ratio_q    <= payload;
				lk_for_best_q <= 1'b1;
			end
			fsp_pkg::ST_RST_WR: idx_q <= idx_q + CIW'(1);
			fsp_pkg::ST_SMP_CHK: begin
				sum_q <= sum_new;
				if ({16'd0, pay_q} < 32'(sum_new)) begin
					res_picked_q <= 6'(idx_q);
					res_ok_q     <= 1'b1;
				end else begin
					idx_q <= idx_q + CIW'(1);
				end
			end
			fsp_pkg::ST_UPD_SETUP: begin
				cdf_best_q <= lk_res_q;
				dep_q      <= upd_dep;
				acc_q      <= '0;
				if (!upd_dep) begin
					phase_q <= fsp_pkg::PH_UP;
					idx_q   <= '0;
				end else if (slot_q == 12'd0) begin
					phase_q <= fsp_pkg::PH_MID;
					idx_q   <= '0;
				end else begin
					phase_q <= fsp_pkg::PH_DOWN;
					idx_q   <= CIW'(slot_q) - CIW'(1);
				end
			end
			fsp_pkg::ST_CAND_ACC: acc_q <= acc_new;
			fsp_pkg::ST_CAND_REACH: begin
				wt_q          <= '0;
				lk_ratio_q    <= ratio_rd_q;
				lk_for_best_q <= 1'b0;
				if (ratio_rd_q > pay_q)
					better_q <= 1'b1;
			end
			fsp_pkg::ST_CAND_WT: begin
				if (p_new > maxp_q)
					maxp_q <= p_new;
				wt_q <= p_new * prior_rd_q;
			end
			fsp_pkg::ST_CAND_WR: begin
				total_q <= total_q + TOT_W'(wt_q);
				if (walk_done) begin
					idx_q <= '0;
				end else begin
					case (phase_q)
						fsp_pkg::PH_DOWN: begin
							if (idx_q == '0) begin
								phase_q <= fsp_pkg::PH_MID;
								idx_q   <= CIW'(slot_q);
							end else begin
								idx_q <= idx_q - CIW'(1);
							end
						end
						fsp_pkg::PH_MID: begin
							phase_q <= fsp_pkg::PH_UP;
							acc_q   <= '0;
							idx_q   <= CIW'(slot_q) + CIW'(1);
						end
						default: idx_q <= idx_q + CIW'(1);
					endcase
				end
			end
			fsp_pkg::ST_NORM_WAIT: begin
				if (total_q == '0 || div_done)
					idx_q <= idx_q + CIW'(1);
			end
			fsp_pkg::ST_LK_MUL: lk_prod_q <= lk_ratio_q * cdf_last_q;
			fsp_pkg::ST_LK_SPLIT: begin
				lk_frac_q  <= split_d.r;
				lk_clamp_q <= split_clamp;
				lk_addr_q  <= split_addr;
			end
			fsp_pkg::ST_LK_LO: begin
				lk_lo_q  <= cdf_rd_q;
				lk_res_q <= cdf_rd_q;
			end
			fsp_pkg::ST_LK_HI: begin
				lk_up_q    <= cdf_rd_q >= lk_lo_q;
				lk_prod2_q <= ((cdf_rd_q >= lk_lo_q) ? (cdf_rd_q - lk_lo_q) :
					(lk_lo_q - cdf_rd_q)) * lk_frac_q;
			end
			fsp_pkg::ST_LK_INT: begin
				lk_res_q <= lk_up_q ? (lk_lo_q + int_d.q[15:0]) : (lk_lo_q - int_d.q[15:0]);
			end
			fsp_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					picked_q  <= res_picked_q;
					pick_ok_q <= res_ok_q;
					if (cmd_q == fsp_pkg::CMD_UPDATE) begin
						max_out_q    <= maxp_q;
						better_out_q <= better_q;
						finished_q   <= maxp_q == 16'd0;
					end else begin
						max_out_q    <= '0;
						better_out_q <= 1'b0;
						finished_q   <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign picked          = picked_q;
	assign pick_ok         = pick_ok_q;
	assign max_chance      = max_out_q;
	assign better_possible = better_out_q;
	assign finished        = finished_q;

endmodule

`default_nettype wire

// ----- src/fsp_check.sv -----
// ----------------------------------------------------------------------------
// fsp_check
// Port-level checks on the result channel of the sampling engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [5:0]  picked,
	input wire logic        pick_ok,
	input wire logic [15:0] max_chance,
	input wire logic        better_possible,
	input wire logic        finished
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(max_chance) && $stable(picked))
		else $error("stalled result beat changed");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> max_chance == 16'd0)
		else $error("finished with nonzero max_chance");

	a_pick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pick_ok |-> max_chance == 16'd0 && !better_possible && !finished)
		else $error("sample beat carries update fields");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pick_ok |-> picked == 6'd0)
		else $error("missed draw reports a candidate");

endmodule

bind focal_sampling_probability_engine fsp_check u_fsp_check (.*);

`default_nettype wire

// ----- bench/focal_sampling_probability_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// focal_sampling_probability_engine_tb
// Fills the cdf, ratio and prior tables, runs a table of directed commands,
// then random command streams under several register settings. Every
// command's result is predicted in the bench or taken from the directed
// table, and checked field by field, with random gaps on the input side and
// random stalls on the output side.
module focal_sampling_probability_engine_tb;

	localparam int NCAND     = 64;
	localparam int CDF_ENTRIES = 1024;
	localparam int RATIO_ENTRIES = 4096;
	// cdf_last never exceeds 255 and counts stay below 128 between restarts
	localparam int CDF_FILL = 256;
	localparam int RATIO_FILL = 128;
	localparam int NUM_PHASES = 11;
	localparam int PHASE_BEATS = 62;
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [5:0]  picked;
		logic        pick_ok;
		logic [15:0] max_chance;
		logic        better_possible;
		logic        finished;
	} outcome_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [11:0] slot;
		logic [15:0] value;
		logic        known;
		logic        typed;
		outcome_t    want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  command;
	logic [11:0] slot;
	logic [15:0] payload;
	logic        best_known;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  picked;
	logic        pick_ok;
	logic [15:0] max_chance;
	logic        better_possible;
	logic        finished;

	focal_sampling_probability_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .slot(slot), .payload(payload), .best_known(best_known),
		.out_valid(out_valid), .out_stall(out_stall),
		.picked(picked), .pick_ok(pick_ok), .max_chance(max_chance),
		.better_possible(better_possible), .finished(finished)
	);

	// bench copy of the block state
	logic [15:0] cdf_mem [CDF_ENTRIES];
	logic [15:0] ratio_mem [RATIO_ENTRIES];
	logic [15:0] prior_mem [NCAND];
	logic [15:0] chance_mem [NCAND];
	logic [31:0] draws [NCAND];
	logic [6:0]  r_num_cand;
	logic [9:0]  r_cdf_last;
	logic [11:0] r_iter_last;
	logic [15:0] r_min_ratio;

	logic [15:0] upd_max;
	bit          upd_better;

	outcome_t    outcome_q[$];
	int          err_cnt;
	int          beats_out;
	bit          gaps_on;
	bit          held_once;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int active_cands();
		int n;
		n = r_num_cand;
		if (n == 0) n = 1;
		if (n > NCAND) n = NCAND;
		return n;
	endfunction

	function automatic logic [15:0] cdf_of(input logic [15:0] ratio);
		longint unsigned prod, f, frac, lo, hi, idx;
		prod = longint'(ratio) * longint'(r_cdf_last);
		f    = prod / 65535;
		frac = prod % 65535;
		if (f >= r_cdf_last || f >= CDF_ENTRIES - 1) begin
			idx = (f < CDF_ENTRIES - 1) ? f : CDF_ENTRIES - 1;
			return cdf_mem[idx];
		end
		lo = cdf_mem[f];
		hi = cdf_mem[f + 1];
		if (hi >= lo) return 16'(lo + ((hi - lo) * frac) / 65535);
		return 16'(lo - ((lo - hi) * frac) / 65535);
	endfunction

	// weight of one candidate; keeps the running max and the better flag
	function automatic longint unsigned weight_of(input int i, input longint unsigned cnt,
			input logic [15:0] best, input logic [15:0] cdf_best);
		logic [15:0] reach, cr, p;
		reach = ratio_mem[(cnt > r_iter_last) ? r_iter_last : cnt];
		if (reach <= best) return 0;
		upd_better = 1'b1;
		cr = cdf_of(reach);
		p  = (cr > cdf_best) ? cr - cdf_best : 16'd0;
		if (p > upd_max) upd_max = p;
		return longint'(p) * longint'(prior_mem[i]);
	endfunction

	function automatic outcome_t engine_step(input logic [2:0] c, input logic [11:0] s,
			input logic [15:0] v, input logic k);
		outcome_t          r;
		int                n;
		longint unsigned   sum, total, acc;
		longint unsigned   w [NCAND];
		logic [15:0]       cb;
		r = '0;
		n = active_cands();
		case (c)
			fsp_pkg::CMD_LOAD_CDF: if (s < CDF_ENTRIES) cdf_mem[s] = v;
			fsp_pkg::CMD_LOAD_RATIO: ratio_mem[s] = v;
			fsp_pkg::CMD_LOAD_PRIOR: if (s < NCAND) prior_mem[s] = v;
			fsp_pkg::CMD_RESTART: begin
				for (int i = 0; i < NCAND; i++) begin
					draws[i] = '0;
					chance_mem[i] = (i < n) ? prior_mem[i] : 16'd0;
				end
			end
			fsp_pkg::CMD_SAMPLE: begin
				sum = 0;
				for (int i = 0; i < n; i++) begin
					sum += chance_mem[i];
					if (v < sum) begin
						if (draws[i] != 32'hFFFF_FFFF) draws[i] += 1;
						r.picked  = 6'(i);
						r.pick_ok = 1'b1;
						break;
					end
				end
			end
			fsp_pkg::CMD_UPDATE: begin
				upd_max = '0;
				upd_better = 1'b0;
				total = 0;
				cb = cdf_of(v);
				if (k && s < n && v > r_min_ratio) begin
					acc = 0;
					for (int i = s; i > 0; i--) begin
						acc += draws[i - 1];
						w[i - 1] = weight_of(i - 1, acc, v, cb);
					end
					w[s] = weight_of(s, draws[s], v, cb);
					acc = 0;
					for (int i = s + 1; i < n; i++) begin
						acc += draws[i];
						w[i] = weight_of(i, acc, v, cb);
					end
				end else begin
					for (int i = 0; i < n; i++) w[i] = weight_of(i, draws[i], v, cb);
				end
				for (int i = 0; i < n; i++) total += w[i];
				for (int i = 0; i < n; i++)
					chance_mem[i] = (total != 0) ? 16'((w[i] * 65535) / total) : 16'd0;
				r.max_chance      = upd_max;
				r.better_possible = upd_better;
				r.finished        = (upd_max == 0);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		if (!gaps_on) return 0;
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// drive one beat; enters and leaves at a falling edge
	task automatic send_beat(input logic [2:0] c, input logic [11:0] s, input logic [15:0] v,
			input logic k, input bit typed, input outcome_t want);
		int       gap;
		outcome_t got;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command    = c;
		slot       = s;
		payload    = v;
		best_known = k;
		in_valid   = 1'b1;
		do @(posedge clk); while (in_stall);
		got = engine_step(c, s, v, k);
		outcome_q.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (outcome_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input fsp_pkg::cfg_idx_t idx, input logic [15:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			fsp_pkg::CFG_NUM_CAND:  r_num_cand  = val[6:0];
			fsp_pkg::CFG_CDF_LAST:  r_cdf_last  = val[9:0];
			fsp_pkg::CFG_ITER_LAST: r_iter_last = val[11:0];
			default:                r_min_ratio = val;
		endcase
	endtask

	task automatic random_beat();
		int          n, pick;
		logic [2:0]  c;
		logic [11:0] s;
		logic [15:0] v;
		n    = active_cands();
		pick = $urandom_range(0, 99);
		s    = 12'($urandom_range(0, n - 1));
		v    = 16'($urandom);
		if (pick < 8) begin
			c = fsp_pkg::CMD_LOAD_CDF;
			s = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 1023));
		end else if (pick < 16) begin
			c = fsp_pkg::CMD_LOAD_RATIO;
			s = 12'($urandom);
		end else if (pick < 24) begin
			c = fsp_pkg::CMD_LOAD_PRIOR;
			s = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
		end else if (pick < 32) begin
			c = fsp_pkg::CMD_RESTART;
		end else if (pick < 80) begin
			c = fsp_pkg::CMD_SAMPLE;
			if ($urandom_range(0, 3) == 0) s = 12'($urandom);
		end else if (pick < 97) begin
			c = fsp_pkg::CMD_UPDATE;
			if ($urandom_range(0, 7) == 0) s = 12'($urandom);
			if ($urandom_range(0, 9) == 0) v = r_min_ratio;
		end else begin
			c = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
			s = 12'($urandom);
		end
		send_beat(c, s, v, 1'($urandom), 1'b0, '0);
	endtask

	task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
		$display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
		err_cnt++;
	endtask

	// output side: random stalls plus one long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_once && beats_out >= 150) begin
				held_once = 1'b1;
				out_stall = 1'b1;
				repeat (400) @(negedge clk);
			end else if (gaps_on) begin
				out_stall = ($urandom_range(0, 9) < 3);
				if ($urandom_range(0, 99) == 0) begin
					out_stall = 1'b1;
					repeat ($urandom_range(20, 80)) @(negedge clk);
				end
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			beats_out <= beats_out + 1;
			if (outcome_q.size() == 0) begin
				$display("%0t unexpected result beat: picked %0d max_chance %0h",
					$time, picked, max_chance);
				err_cnt++;
			end else begin
				want = outcome_q.pop_front();
				if (picked != want.picked) report("picked", want.picked, picked);
				if (pick_ok != want.pick_ok) report("pick_ok", want.pick_ok, pick_ok);
				if (max_chance != want.max_chance)
					report("max_chance", want.max_chance, max_chance);
				if (better_possible != want.better_possible)
					report("better_possible", want.better_possible, better_possible);
				if (finished != want.finished) report("finished", want.finished, finished);
			end
		end
	end

	initial begin
		stim_row_t   rows [$];
		logic [6:0]  ph_cand  [NUM_PHASES] = '{64, 3, 0, 127, 5, 2, 8, 1, 17, 4, 64};
		logic [9:0]  ph_cdf   [NUM_PHASES] = '{255, 1, 128, 255, 77, 200, 3, 255, 150, 1, 100};
		logic [11:0] ph_iter  [NUM_PHASES] = '{4095, 0, 7, 4095, 20, 100, 3, 4095, 15, 2, 4095};
		logic [15:0] ph_minr  [NUM_PHASES] = '{6554, 1, 65535, 6554, 30000, 1000, 500, 65535,
			20000, 1, 40000};

		err_cnt = 0;
		beats_out = 0;
		held_once = 1'b0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = fsp_pkg::CFG_NUM_CAND;
		cfg_data = '0;
		in_valid = 1'b0;
		command = fsp_pkg::CMD_LOAD_CDF;
		slot = '0;
		payload = '0;
		best_known = 1'b0;
		for (int i = 0; i < NCAND; i++) begin
			chance_mem[i] = '0;
			draws[i] = '0;
		end
		r_num_cand = 7'd1;
		r_cdf_last = 10'd1023;
		r_iter_last = 12'd4095;
		r_min_ratio = 16'd6554;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// keep cdf lookups inside the filled part of the table
		write_reg(fsp_pkg::CFG_CDF_LAST, 16'(CDF_FILL - 1));

		// fill every reachable entry so no update reads an unwritten one
		for (int i = 0; i < CDF_FILL; i++)
			send_beat(fsp_pkg::CMD_LOAD_CDF, 12'(i), 16'((i * 256) | $urandom_range(0, 255)),
				1'b0, 1'b0, '0);
		for (int i = 0; i < RATIO_FILL; i++)
			send_beat(fsp_pkg::CMD_LOAD_RATIO, 12'(i), 16'($urandom), 1'b0, 1'b0, '0);
		for (int i = 0; i < NCAND; i++)
			send_beat(fsp_pkg::CMD_LOAD_PRIOR, 12'(i), 16'($urandom), 1'b0, 1'b0, '0);

		// sender pauses until every result is in
		drain();

		// directed rows: unused codes, edge-slot loads, a miss before restart
		rows.push_back('{CMD_SPARE_LO, 12'hFFF, 16'hFFFF, 1'b1, 1'b1, '0});
		rows.push_back('{CMD_SPARE_HI, 12'hFFF, 16'hFFFF, 1'b1, 1'b1, '0});
		rows.push_back('{fsp_pkg::CMD_LOAD_CDF, 12'hFFF, 16'hFFFF, 1'b1, 1'b1, '0});
		rows.push_back('{fsp_pkg::CMD_LOAD_PRIOR, 12'd64, 16'hFFFF, 1'b0, 1'b1, '0});
		rows.push_back('{fsp_pkg::CMD_LOAD_RATIO, 12'hFFF, 16'hFFFF, 1'b0, 1'b1, '0});
		rows.push_back('{fsp_pkg::CMD_SAMPLE, 12'd0, 16'd0, 1'b0, 1'b1, '0});
		rows.push_back('{fsp_pkg::CMD_RESTART, 12'd0, 16'd0, 1'b0, 1'b1, '0});
		rows.push_back('{fsp_pkg::CMD_SAMPLE, 12'd0, 16'd0, 1'b0, 1'b0, '0});
		rows.push_back('{fsp_pkg::CMD_SAMPLE, 12'hFFF, 16'hFFFF, 1'b1, 1'b0, '0});
		rows.push_back('{fsp_pkg::CMD_UPDATE, 12'd0, 16'd0, 1'b0, 1'b0, '0});
		rows.push_back('{fsp_pkg::CMD_UPDATE, 12'd0, 16'hFFFF, 1'b1, 1'b0, '0});
		rows.push_back('{fsp_pkg::CMD_UPDATE, 12'd0, 16'd6554, 1'b1, 1'b0, '0});
		rows.push_back('{fsp_pkg::CMD_UPDATE, 12'hFFF, 16'd9000, 1'b1, 1'b0, '0});
		rows.push_back('{fsp_pkg::CMD_UPDATE, 12'd0, 16'd1, 1'b1, 1'b0, '0});
		rows.push_back('{fsp_pkg::CMD_SAMPLE, 12'd0, 16'd100, 1'b0, 1'b0, '0});
		rows.push_back('{fsp_pkg::CMD_UPDATE, 12'd0, 16'd20000, 1'b1, 1'b0, '0});
		rows.push_back('{fsp_pkg::CMD_RESTART, 12'd0, 16'd0, 1'b0, 1'b0, '0});
		foreach (rows[i])
			send_beat(rows[i].cmd, rows[i].slot, rows[i].value, rows[i].known,
				rows[i].typed, rows[i].want);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			write_reg(fsp_pkg::CFG_NUM_CAND, {9'($urandom), ph_cand[ph]});
			write_reg(fsp_pkg::CFG_CDF_LAST, 16'(ph_cdf[ph]));
			write_reg(fsp_pkg::CFG_ITER_LAST, 16'(ph_iter[ph]));
			write_reg(fsp_pkg::CFG_MIN_RATIO, ph_minr[ph]);
			gaps_on = (ph % 4 != 3);
			send_beat(fsp_pkg::CMD_RESTART, '0, '0, 1'b0, 1'b0, '0);
			for (int b = 0; b < PHASE_BEATS; b++) random_beat();
		end

		drain();
		repeat (100) @(posedge clk);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/fsp_pkg.sv
src/fsp_div.sv
src/focal_sampling_probability_engine.sv
src/fsp_check.sv
bench/focal_sampling_probability_engine_tb.sv
